// ===== src/fcb_pkg.sv =====
// Shared types, constants and the pixel layout conversion for the
// centering flip blitter. No dependencies.
package fcb_pkg;

  localparam int CoordBits = 11;
  localparam int RegBits   = 11;
  localparam int PixBits   = 16;

  typedef enum logic [2:0] {
    REG_SCREEN_W  = 3'd0,
    REG_SCREEN_H  = 3'd1,
    REG_SOURCE_W  = 3'd2,
    REG_SOURCE_H  = 3'd3,
    REG_LAYOUT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    LAYOUT_RGB16    = 3'd0,
    LAYOUT_RGB16_SW = 3'd1,
    LAYOUT_BGR16    = 3'd2,
    LAYOUT_BGR16_SW = 3'd3,
    LAYOUT_RGB15    = 3'd4,
    LAYOUT_RGB15_SW = 3'd5,
    LAYOUT_BGR15    = 3'd6,
    LAYOUT_BGR15_SW = 3'd7
  } layout_e;

  typedef struct packed {
    logic [RegBits-1:0] screen_w;
    logic [RegBits-1:0] screen_h;
    logic [RegBits-1:0] source_w;
    logic [RegBits-1:0] source_h;
    layout_e            layout;
  } cfg_t;

  localparam logic [RegBits-1:0] ScreenWReset = 11'd320;
  localparam logic [RegBits-1:0] ScreenHReset = 11'd200;
  localparam logic [RegBits-1:0] SourceWReset = 11'd320;
  localparam logic [RegBits-1:0] SourceHReset = 11'd200;

  function automatic logic [PixBits-1:0] swap_bytes(input logic [PixBits-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Convert an RGB565 pixel into the selected output layout.
  function automatic logic [PixBits-1:0] convert_pixel(input logic [PixBits-1:0] p,
                                                       input layout_e layout);
    logic [PixBits-1:0] q;
    q = p;
    case (layout) inside
      LAYOUT_RGB16, LAYOUT_RGB16_SW: q = p;
      LAYOUT_BGR16, LAYOUT_BGR16_SW: q = {p[4:0], p[10:5], p[15:11]};
      // 15-bit forms drop the low green bit
      LAYOUT_RGB15, LAYOUT_RGB15_SW: q = {1'b0, p[15:11], p[10:6], p[4:0]};
      LAYOUT_BGR15, LAYOUT_BGR15_SW: q = {1'b0, p[4:0], p[10:6], p[15:11]};
      default:                       q = p;
    endcase
    case (layout) inside
      LAYOUT_RGB16_SW, LAYOUT_BGR16_SW, LAYOUT_RGB15_SW, LAYOUT_BGR15_SW:
        q = swap_bytes(q);
      default: q = q;
    endcase
    return q;
  endfunction

endpackage

// ===== src/fcb_cfg_regs.sv =====
// Configuration register file for the blitter: sizes and pixel layout.
// Depends on fcb_pkg.
module fcb_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [fcb_pkg::RegBits-1:0] cfg_data_i,
  output fcb_pkg::cfg_t              cfg_o
);
  import fcb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_SCREEN_W: cfg_d.screen_w = cfg_data_i;
        REG_SCREEN_H: cfg_d.screen_h = cfg_data_i;
        REG_SOURCE_W: cfg_d.source_w = cfg_data_i;
        REG_SOURCE_H: cfg_d.source_h = cfg_data_i;
        REG_LAYOUT:   cfg_d.layout   = layout_e'(cfg_data_i[2:0]);
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w <= ScreenWReset;
      cfg_q.screen_h <= ScreenHReset;
      cfg_q.source_w <= SourceWReset;
      cfg_q.source_h <= SourceHReset;
      cfg_q.layout   <= LAYOUT_RGB16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/fcb_position.sv =====
// Input register and source column/row counters of the blitter.
// Depends on fcb_pkg.
module fcb_position #(
  parameter int COORD_BITS = fcb_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcb_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fcb_pkg::PixBits-1:0] source_pixel_i,
  input  logic                        frame_start_i,
  input  logic                        advance_i,
  output logic                        st_valid_o,
  output logic [fcb_pkg::PixBits-1:0] st_pixel_o,
  output logic [COORD_BITS-1:0]       st_col_o,
  output logic [COORD_BITS-1:0]       st_row_o
);
  import fcb_pkg::*;

  localparam int CmpW = (COORD_BITS > RegBits) ? COORD_BITS : RegBits;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS-1:0] cur_col, cur_row, inc_col, inc_row;
  logic                  st_valid_q, st_valid_d;
  logic [PixBits-1:0]    st_pixel_q;
  logic [COORD_BITS-1:0] st_col_q, st_row_q;
  logic                  accept;

  assign in_stall_o = st_valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    inc_col = cur_col + 1'b1;
    inc_row = cur_row + 1'b1;
    col_d   = inc_col;
    row_d   = cur_row;
    // wrap the column at the source width or on counter overflow
    if ((CmpW'(inc_col) >= CmpW'(cfg_i.source_w)) || (inc_col == '0)) begin
      col_d = '0;
      row_d = inc_row;
      if (CmpW'(inc_row) >= CmpW'(cfg_i.source_h)) begin
        row_d = '0;
      end
    end
    st_valid_d = accept ? 1'b1 : (advance_i ? 1'b0 : st_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_pixel_q <= source_pixel_i;
      st_col_q   <= cur_col;
      st_row_q   <= cur_row;
    end
  end

  assign st_valid_o = st_valid_q;
  assign st_pixel_o = st_pixel_q;
  assign st_col_o   = st_col_q;
  assign st_row_o   = st_row_q;

endmodule

// ===== src/fcb_place.sv =====
// Region test, centered and flipped placement, layout conversion and the
// result register of the blitter. Depends on fcb_pkg.
module fcb_place #(
  parameter int COORD_BITS = fcb_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcb_pkg::cfg_t               cfg_i,
  input  logic                        st_valid_i,
  input  logic [fcb_pkg::PixBits-1:0] st_pixel_i,
  input  logic [COORD_BITS-1:0]       st_col_i,
  input  logic [COORD_BITS-1:0]       st_row_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fcb_pkg::RegBits-1:0] screen_x_o,
  output logic [fcb_pkg::RegBits-1:0] screen_y_o,
  output logic [fcb_pkg::PixBits-1:0] screen_pixel_o,
  output logic                        frame_done_o
);
  import fcb_pkg::*;

  localparam int CmpW = (COORD_BITS > RegBits) ? COORD_BITS : RegBits;

  logic [RegBits-1:0] copy_w, copy_h, off_x, off_y, spare_w, spare_h;
  logic [CmpW-1:0]    col_ext, row_ext;
  logic [RegBits-1:0] col_lo, row_lo;
  logic               keep, last;
  logic               out_valid_q, out_valid_d;
  logic [RegBits-1:0] x_q, x_d, y_q, y_d;
  logic [PixBits-1:0] pix_q, pix_d;
  logic               done_q, done_d;

  assign advance_o = !out_valid_q || !out_stall_i;

  always_comb begin
    copy_w  = (cfg_i.source_w < cfg_i.screen_w) ? cfg_i.source_w : cfg_i.screen_w;
    copy_h  = (cfg_i.source_h < cfg_i.screen_h) ? cfg_i.source_h : cfg_i.screen_h;
    spare_w = cfg_i.screen_w - copy_w;
    spare_h = cfg_i.screen_h - copy_h;
    off_x   = spare_w >> 1;
    off_y   = spare_h >> 1;
    col_ext = CmpW'(st_col_i);
    row_ext = CmpW'(st_row_i);
    col_lo  = col_ext[RegBits-1:0];
    row_lo  = row_ext[RegBits-1:0];
    keep    = (col_ext < CmpW'(copy_w)) && (row_ext < CmpW'(copy_h));
    last    = (col_lo == copy_w - 1'b1) && (row_lo == copy_h - 1'b1);
    x_d     = col_lo + off_x;
    // source rows are bottom-up: flip within the copy height
    y_d     = copy_h - 1'b1 - row_lo + off_y;
    pix_d   = convert_pixel(st_pixel_i, cfg_i.layout);
    done_d  = last;
    out_valid_d = advance_o ? (st_valid_i && keep) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      pix_q  <= pix_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign screen_x_o     = x_q;
  assign screen_y_o     = y_q;
  assign screen_pixel_o = pix_q;
  assign frame_done_o   = done_q;

endmodule

// ===== src/flip_center_rgb565_format_blitter.sv =====
// Centering, vertically flipping RGB565 blitter. Takes one source pixel per
// clock, unless stalled, in row-major order (rows bottom-up) and issues one
// screen write per pixel inside the copy region, converted to the configured
// layout. The block sustains one item per cycle while no stall holds it. An
// item is captured in the input register at acceptance and its result is
// loaded into the result register once that register can advance. A stalled
// result stalls the input once both registers hold an item. Position counters
// advance at acceptance. Depends on fcb_pkg and its submodules.
module flip_center_rgb565_format_blitter #(
  parameter int COORD_BITS = fcb_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [fcb_pkg::RegBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fcb_pkg::PixBits-1:0] source_pixel_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fcb_pkg::RegBits-1:0] screen_x_o,
  output logic [fcb_pkg::RegBits-1:0] screen_y_o,
  output logic [fcb_pkg::PixBits-1:0] screen_pixel_o,
  output logic                        frame_done_o
);
  import fcb_pkg::*;

  cfg_t                  cfg;
  logic                  advance;
  logic                  st_valid;
  logic [PixBits-1:0]    st_pixel;
  logic [COORD_BITS-1:0] st_col, st_row;

  fcb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fcb_position #(.COORD_BITS(COORD_BITS)) u_position (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_pixel_i (source_pixel_i),
    .frame_start_i  (frame_start_i),
    .advance_i      (advance),
    .st_valid_o     (st_valid),
    .st_pixel_o     (st_pixel),
    .st_col_o       (st_col),
    .st_row_o       (st_row)
  );

  fcb_place #(.COORD_BITS(COORD_BITS)) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .st_valid_i     (st_valid),
    .st_pixel_i     (st_pixel),
    .st_col_i       (st_col),
    .st_row_i       (st_row),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .screen_pixel_o (screen_pixel_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for flip_center_rgb565_format_blitter: streams RGB565
// pixels under several screen/source geometries and layouts, and compares every
// screen write with a directed expected write or an in-bench placement and color-conversion model.
// Depends on fcb_pkg and the blitter RTL.
module tb;
  import fcb_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseItems = 240;
  localparam logic [RegBits-1:0] FullSpan = 11'd2047;
  localparam logic [RegBits-1:0] HalfSpan = 11'd1023;

  typedef struct packed {
    logic [RegBits-1:0] x;
    logic [RegBits-1:0] y;
    logic [PixBits-1:0] pix;
    logic               done;
  } screen_write_t;

  typedef struct packed {
    logic [RegBits-1:0] screen_w;
    logic [RegBits-1:0] screen_h;
    logic [RegBits-1:0] source_w;
    logic [RegBits-1:0] source_h;
    layout_e            layout;
    logic [PixBits-1:0] pixel;
    logic               start;
    logic               hit;
    logic [RegBits-1:0] wx;
    logic [RegBits-1:0] wy;
    logic [PixBits-1:0] wpix;
    logic               wdone;
  } blit_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [RegBits-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [PixBits-1:0] source_pixel_i = '0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [RegBits-1:0] screen_x_o;
  logic [RegBits-1:0] screen_y_o;
  logic [PixBits-1:0] screen_pixel_o;
  logic               frame_done_o;

  flip_center_rgb565_format_blitter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_pixel_i (source_pixel_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .screen_pixel_o (screen_pixel_o),
    .frame_done_o   (frame_done_o)
  );

  // Bench copy of the block state
  cfg_t          regs = '{ScreenWReset, ScreenHReset, SourceWReset, SourceHReset, LAYOUT_RGB16};
  int            pos_col = 0;
  int            pos_row = 0;
  screen_write_t pending_writes[$];
  int            mismatches = 0;
  int            send_idle = 0;
  int            recv_idle = 0;
  int            quiet = 0;

  blit_row_t directed_rows [22] = '{
    '{ScreenWReset, ScreenHReset, SourceWReset, SourceHReset, LAYOUT_RGB16,
      16'hFFFF, 1'b1, 1'b1, 11'd0, 11'd199, 16'hFFFF, 1'b0},
    '{ScreenWReset, ScreenHReset, SourceWReset, SourceHReset, LAYOUT_RGB16,
      16'h0000, 1'b0, 1'b1, 11'd1, 11'd199, 16'h0000, 1'b0},
    // single-pixel source centered on a full-size screen, one row per layout
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_RGB16,
      16'h8001, 1'b1, 1'b1, HalfSpan, HalfSpan, 16'h8001, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_RGB16_SW,
      16'h1234, 1'b1, 1'b1, HalfSpan, HalfSpan, 16'h3412, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_BGR16,
      16'hF800, 1'b0, 1'b1, HalfSpan, HalfSpan, 16'h001F, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_BGR16_SW,
      16'h001F, 1'b1, 1'b1, HalfSpan, HalfSpan, 16'h00F8, 1'b1},
    // low green bit alone vanishes in the 15-bit forms
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_RGB15,
      16'h0020, 1'b0, 1'b1, HalfSpan, HalfSpan, 16'h0000, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_RGB15_SW,
      16'hF800, 1'b1, 1'b1, HalfSpan, HalfSpan, 16'h007C, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_BGR15,
      16'hF800, 1'b0, 1'b1, HalfSpan, HalfSpan, 16'h001F, 1'b1},
    '{FullSpan, FullSpan, 11'd1, 11'd1, LAYOUT_BGR15_SW,
      16'h07C0, 1'b1, 1'b1, HalfSpan, HalfSpan, 16'hE003, 1'b1},
    // empty region from a zero width or height
    '{11'd0, ScreenHReset, SourceWReset, SourceHReset, LAYOUT_RGB16,
      16'h5555, 1'b1, 1'b0, 11'd0, 11'd0, 16'h0000, 1'b0},
    '{ScreenWReset, ScreenHReset, SourceWReset, 11'd0, LAYOUT_RGB16,
      16'hAAAA, 1'b1, 1'b0, 11'd0, 11'd0, 16'h0000, 1'b0},
    // source larger than screen: columns past the region are dropped
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0001, 1'b1, 1'b1, 11'd0, 11'd1, 16'h0001, 1'b0},
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0002, 1'b0, 1'b1, 11'd1, 11'd1, 16'h0002, 1'b0},
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0003, 1'b0, 1'b0, 11'd0, 11'd0, 16'h0000, 1'b0},
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0004, 1'b0, 1'b0, 11'd0, 11'd0, 16'h0000, 1'b0},
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0005, 1'b0, 1'b1, 11'd0, 11'd0, 16'h0005, 1'b0},
    '{11'd2, 11'd2, 11'd4, 11'd3, LAYOUT_RGB16,
      16'h0006, 1'b0, 1'b1, 11'd1, 11'd0, 16'h0006, 1'b1},
    // small source centered on a bigger screen
    '{11'd5, 11'd4, 11'd2, 11'd2, LAYOUT_RGB16,
      16'h0101, 1'b1, 1'b1, 11'd1, 11'd2, 16'h0101, 1'b0},
    '{11'd5, 11'd4, 11'd2, 11'd2, LAYOUT_RGB16,
      16'h0202, 1'b0, 1'b1, 11'd2, 11'd2, 16'h0202, 1'b0},
    '{11'd5, 11'd4, 11'd2, 11'd2, LAYOUT_RGB16,
      16'h0303, 1'b0, 1'b1, 11'd1, 11'd1, 16'h0303, 1'b0},
    '{11'd5, 11'd4, 11'd2, 11'd2, LAYOUT_RGB16,
      16'h0404, 1'b0, 1'b1, 11'd2, 11'd1, 16'h0404, 1'b1}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PixBits-1:0] recolor(input logic [PixBits-1:0] p,
                                                 input layout_e lay);
    logic [4:0]         red;
    logic [4:0]         blue;
    logic [4:0]         green5;
    logic [PixBits-1:0] q;
    red    = p[15:11];
    blue   = p[4:0];
    green5 = p[10:6];
    case (lay)
      LAYOUT_BGR16, LAYOUT_BGR16_SW: q = {blue, p[10:5], red};
      LAYOUT_RGB15, LAYOUT_RGB15_SW: q = {1'b0, red, green5, blue};
      LAYOUT_BGR15, LAYOUT_BGR15_SW: q = {1'b0, blue, green5, red};
      default:                       q = p;
    endcase
    case (lay)
      LAYOUT_RGB16_SW, LAYOUT_BGR16_SW, LAYOUT_RGB15_SW, LAYOUT_BGR15_SW: begin
        q = {q[7:0], q[15:8]};
      end
      default: ;
    endcase
    return q;
  endfunction

  // Place one source pixel and advance the position counters.
  function automatic bit place_pixel(input logic [PixBits-1:0] px, input logic st,
                                     output screen_write_t w);
    int copy_w;
    int copy_h;
    int off_x;
    int off_y;
    bit hit;
    if (st) begin
      pos_col = 0;
      pos_row = 0;
    end
    copy_w = (regs.source_w < regs.screen_w) ? int'(regs.source_w) : int'(regs.screen_w);
    copy_h = (regs.source_h < regs.screen_h) ? int'(regs.source_h) : int'(regs.screen_h);
    off_x  = (int'(regs.screen_w) - copy_w) / 2;
    off_y  = (int'(regs.screen_h) - copy_h) / 2;
    hit    = (pos_col < copy_w) && (pos_row < copy_h);
    w      = '0;
    if (hit) begin
      w.x    = RegBits'(pos_col + off_x);
      w.y    = RegBits'(copy_h - 1 - pos_row + off_y);
      w.pix  = recolor(px, regs.layout);
      w.done = (pos_col == copy_w - 1) && (pos_row == copy_h - 1);
    end
    pos_col = (pos_col + 1) % (1 << CoordBits);
    if (pos_col >= int'(regs.source_w) || pos_col == 0) begin
      pos_col = 0;
      pos_row = (pos_row + 1) % (1 << CoordBits);
      if (pos_row >= int'(regs.source_h)) pos_row = 0;
    end
    return hit;
  endfunction

  task automatic push_pixel(input logic [PixBits-1:0] px, input logic st,
                            input bit typed, input bit t_hit, input screen_write_t t_w);
    screen_write_t w;
    bit            hit;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    source_pixel_i <= px;
    frame_start_i  <= st;
    do @(posedge clk_i); while (in_stall_o);
    hit = place_pixel(px, st, w);
    if (typed) begin
      hit = t_hit;
      w   = t_w;
    end
    if (hit) pending_writes.push_back(w);
  endtask

  // Drain the pipeline, then write all five registers.
  task automatic retune(input cfg_t c);
    cfg_idx_e           idx;
    logic [RegBits-1:0] val;
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int i = REG_SCREEN_W; i <= REG_LAYOUT; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        REG_SCREEN_W: val = c.screen_w;
        REG_SCREEN_H: val = c.screen_h;
        REG_SOURCE_W: val = c.source_w;
        REG_SOURCE_H: val = c.source_h;
        default:      val = {8'd0, c.layout};
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    regs = c;
  endtask

  // Write sink: random stall, compare each accepted write with the oldest pending one.
  always @(posedge clk_i) begin : sink
    screen_write_t got;
    screen_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{screen_x_o, screen_y_o, screen_pixel_o, frame_done_o};
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write: x=%0d y=%0d pix=%h done=%b",
                   got.x, got.y, got.pix, got.done);
      end else begin
        want = pending_writes.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.pix !== want.pix ||
            got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("write mismatch: exp x=%0d y=%0d pix=%h done=%b, got x=%0d y=%0d pix=%h done=%b",
                     want.x, want.y, want.pix, want.done,
                     got.x, got.y, got.pix, got.done);
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("[flip_center_rgb565_format_blitter] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    cfg_t          next_cfg;
    screen_write_t t_w;
    send_idle = 31;
    recv_idle = 58;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      next_cfg = '{directed_rows[i].screen_w, directed_rows[i].screen_h,
                   directed_rows[i].source_w, directed_rows[i].source_h,
                   directed_rows[i].layout};
      if (next_cfg != regs) retune(next_cfg);
      t_w = '{directed_rows[i].wx, directed_rows[i].wy, directed_rows[i].wpix,
              directed_rows[i].wdone};
      push_pixel(directed_rows[i].pixel, directed_rows[i].start, 1'b1,
                 directed_rows[i].hit, t_w);
    end

    for (int ph = 0; ph < 6; ph++) begin
      // receiver-heavy idling, then sender-heavy, then none
      if (ph < 2) begin
        send_idle = 31;
        recv_idle = 58;
      end else if (ph < 4) begin
        send_idle = 58;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      next_cfg.screen_w = RegBits'($urandom_range(1, 12));
      next_cfg.screen_h = RegBits'($urandom_range(1, 12));
      next_cfg.source_w = RegBits'($urandom_range(1, 12));
      next_cfg.source_h = RegBits'($urandom_range(1, 12));
      next_cfg.layout   = layout_e'($urandom_range(0, 7));
      if (ph == 1) begin
        // widest source on the largest screen
        next_cfg.screen_w = FullSpan;
        next_cfg.screen_h = FullSpan;
        next_cfg.source_w = FullSpan;
        next_cfg.source_h = 11'd3;
      end else if (ph == 3) begin
        // one-column source, tallest extent: y starts at the top row
        next_cfg.screen_w = 11'd1;
        next_cfg.screen_h = FullSpan;
        next_cfg.source_w = 11'd1;
        next_cfg.source_h = FullSpan;
      end
      retune(next_cfg);
      for (int k = 0; k < PhaseItems; k++)
        push_pixel(PixBits'($urandom), (k == 0) || ($urandom_range(0, 49) == 0),
                   1'b0, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("[flip_center_rgb565_format_blitter] OK");
    end else begin
      $display("[flip_center_rgb565_format_blitter] ERROR");
    end
    $finish;
  end

endmodule

// ===== flip_center_rgb565_format_blitter.f =====
src/fcb_pkg.sv
src/fcb_cfg_regs.sv
src/fcb_position.sv
src/fcb_place.sv
src/flip_center_rgb565_format_blitter.sv
sim/tb.sv
